// ===== hdl/box_blur_3x3_rgb_unit_macros.svh =====
// Assertion macros shared by the box blur unit's modules.
`ifndef BOX_BLUR_3X3_RGB_UNIT_MACROS_SVH
`define BOX_BLUR_3X3_RGB_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BBR_CHK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BBR_CHK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bbr_pkg.sv =====
// Shared types, widths and codes of the box blur unit.
package bbr_pkg;

  // Pixel channels
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  typedef logic [CH_W-1:0] chan_t;
  // index 2 = red, 1 = green, 0 = blue
  typedef chan_t [NUM_CH-1:0] rgb_t;

  // Frame geometry
  localparam int ROW_W         = 12;
  localparam int COL_OUT_W     = 10;
  localparam int WID_W         = 11;
  localparam int HGT_W         = 13;
  localparam int MAX_HEIGHT    = 4096;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam logic [WID_W-1:0] WID_RST = 11'd1024;
  localparam logic [HGT_W-1:0] HGT_RST = 13'd768;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

  // Window and arithmetic sizes
  localparam int WIN_N     = 9;
  localparam int IDX_W     = 4;
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = 2;
  localparam int SUM_W     = 12;  // 9 * 255 fits
  localparam int CNT_W     = 4;   // up to 9 pixels
  localparam int NUM_W     = 13;  // 2*sum + count
  localparam int DSR_W     = 5;   // 2*count, up to 18
  localparam int REM_W     = 5;   // remainder stays below the divisor
  localparam int DIV_STEPS = 8;
  localparam int DSTEP_W   = 3;

  // Shared unit operations
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_HOLD  = 2'd0;
  localparam alu_op_t ALU_ACC   = 2'd1;
  localparam alu_op_t ALU_DINIT = 2'd2;
  localparam alu_op_t ALU_DSTEP = 2'd3;

  typedef struct packed {
    alu_op_t op;
    logic    first;
    logic    incl;
  } alu_ctl_t;

  // One line buffer entry: both rows above at one column
  typedef struct packed {
    rgb_t two_above;
    rgb_t above;
  } line_pair_t;

  typedef struct packed {
    logic              first_of_frame;
    logic [CH_W-1:0]   in_red;
    logic [CH_W-1:0]   in_green;
    logic [CH_W-1:0]   in_blue;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]      out_red;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_blue;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 last_of_run;
  } out_t;

endpackage

// ===== hdl/bbr_line_mem.sv =====
// Line buffer memory: the two rows above, one entry per column, registered read.
module bbr_line_mem #(
  parameter int MAX_WIDTH = bbr_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  logic                         we,
  input  bbr_pkg::line_pair_t          wdata,
  output bbr_pkg::line_pair_t          rdata
);
  import bbr_pkg::*;

  line_pair_t mem_q [MAX_WIDTH];
  line_pair_t rdata_r;

  // Single port: read old contents, write when asked
  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end
    rdata_r <= mem_q[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bbr_alu.sv =====
// Shared three-lane unit: masked accumulate and one restoring divide step per cycle.
`include "box_blur_3x3_rgb_unit_macros.svh"
module bbr_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  bbr_pkg::alu_ctl_t ctl,
  input  bbr_pkg::rgb_t     pix,
  output bbr_pkg::rgb_t     quo
);
  import bbr_pkg::*;

  logic [SUM_W-1:0] sum_r   [NUM_CH];
  logic [SUM_W-1:0] sum_nxt [NUM_CH];
  logic [REM_W-1:0] rem_r   [NUM_CH];
  logic [REM_W-1:0] rem_nxt [NUM_CH];
  chan_t            quo_r   [NUM_CH];
  chan_t            quo_nxt [NUM_CH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DSR_W-1:0] dsr;
  logic [NUM_W-1:0] num  [NUM_CH];
  logic [REM_W:0]   shf  [NUM_CH];
  logic [REM_W:0]   diff [NUM_CH];

  // Divisor is twice the pixel count
  assign dsr = {cnt_r, 1'b0};

  // Per-lane numerator and trial subtraction
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      num[i]  = {sum_r[i], 1'b0} + NUM_W'(cnt_r);
      shf[i]  = {rem_r[i], quo_r[i][CH_W-1]};
      diff[i] = shf[i] - (REM_W+1)'(dsr);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < NUM_CH; i++) begin
      sum_nxt[i] = sum_r[i];
      rem_nxt[i] = rem_r[i];
      quo_nxt[i] = quo_r[i];
    end
    case (ctl.op)
      ALU_ACC: begin
        cnt_nxt = (ctl.first ? '0 : cnt_r) + CNT_W'(ctl.incl);
        for (int i = 0; i < NUM_CH; i++) begin
          sum_nxt[i] = (ctl.first ? '0 : sum_r[i]) +
                       (ctl.incl ? SUM_W'(pix[i]) : '0);
        end
      end
      ALU_DINIT: begin
        // quotient is below 256, so the top bits start below the divisor
        for (int i = 0; i < NUM_CH; i++) begin
          rem_nxt[i] = num[i][NUM_W-1:CH_W];
          quo_nxt[i] = num[i][CH_W-1:0];
        end
      end
      ALU_DSTEP: begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (shf[i] >= (REM_W+1)'(dsr)) begin
            rem_nxt[i] = diff[i][REM_W-1:0];
            quo_nxt[i] = {quo_r[i][CH_W-2:0], 1'b1};
          end else begin
            rem_nxt[i] = shf[i][REM_W-1:0];
            quo_nxt[i] = {quo_r[i][CH_W-2:0], 1'b0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    for (int i = 0; i < NUM_CH; i++) begin
      sum_r[i] <= sum_nxt[i];
      rem_r[i] <= rem_nxt[i];
      quo_r[i] <= quo_nxt[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      quo[i] = quo_r[i];
    end
  end

  `BBR_CHK_NOW(a_rem_below_div, ctl.op == ALU_DSTEP, (rem_r[0] < dsr) && (rem_r[1] < dsr) && (rem_r[2] < dsr), "remainder not below divisor")
  `BBR_CHK_NOW(a_cnt_range, ctl.op == ALU_DINIT, (cnt_r != '0) && (cnt_r <= CNT_W'(WIN_N)), "pixel count out of range")
  `BBR_CHK_NEXT(a_first_acc, (ctl.op == ALU_ACC) && ctl.first, cnt_r == CNT_W'($past(ctl.incl)), "first accumulate did not restart count")

endmodule

// ===== hdl/bbr_ctrl.sv =====
// Sequencer: position counters, 3x3 window, config registers and output register.
`include "box_blur_3x3_rgb_unit_macros.svh"
module bbr_ctrl #(
  parameter int MAX_WIDTH = bbr_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bbr_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bbr_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [$clog2(MAX_WIDTH)-1:0]   mem_addr,
  output logic                           mem_we,
  output bbr_pkg::line_pair_t            mem_wdata,
  input  bbr_pkg::line_pair_t            mem_rdata,
  output bbr_pkg::alu_ctl_t              alu_ctl,
  output bbr_pkg::rgb_t                  alu_pix,
  input  bbr_pkg::rgb_t                  alu_quo
);
  import bbr_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW_W  = (WID_W > $clog2(MAX_WIDTH + 1)) ? WID_W : $clog2(MAX_WIDTH + 1);
  localparam int CX_W  = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_DINIT = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [NUM_SLOTS-1:0] pend_r, pend_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [DSTEP_W-1:0]   dcnt_r, dcnt_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]     cur_col_r, cur_col_nxt;
  rgb_t                 px_r, px_nxt;
  rgb_t                 win_r   [WIN_N];
  rgb_t                 win_nxt [WIN_N];
  logic [WID_W-1:0]     wid_r, wid_nxt;
  logic [HGT_W-1:0]     hgt_r, hgt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  logic [EW_W-1:0]      w_eff;
  logic [HGT_W-1:0]     h_eff;
  logic                 in_acc;
  logic [HGT_W-1:0]     r0, r1, r2, rn;
  logic [EW_W-1:0]      c0, c1, cn;
  logic                 r_ge1, r_ge2, c_ge1, c_ge2, r_last, c_last;
  logic [WIN_N-1:0]     mask_w;
  logic [NUM_SLOTS-1:0] slot_bit, rest;
  logic                 emit_go;
  logic [CX_W-1:0]      colx;

  // Lowest pending result goes first (raster order)
  function automatic logic [SLOT_W-1:0] first_slot(input logic [NUM_SLOTS-1:0] p);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (p[i]) begin
        s = SLOT_W'(i);
      end
    end
    return s;
  endfunction

  // Window cells inside the frame for the blurred pixel of a slot
  function automatic logic [WIN_N-1:0] cell_mask(input logic [SLOT_W-1:0] s,
                                                 input logic rg1, input logic rg2,
                                                 input logic cg1, input logic cg2);
    logic [2:0]       rok;
    logic [2:0]       cok;
    logic [WIN_N-1:0] m;
    rok = {1'b1, rg1, !s[1] && rg2};
    cok = {1'b1, cg1, !s[0] && cg2};
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        m[k*3+j] = rok[k] && cok[j];
      end
    end
    return m;
  endfunction

  // Effective frame size
  always_comb begin
    if (wid_r == '0) begin
      w_eff = EW_W'(1);
    end else if (EW_W'(wid_r) > EW_W'(MAX_WIDTH)) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(wid_r);
    end
    if (hgt_r == '0) begin
      h_eff = HGT_W'(1);
    end else if (hgt_r > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = hgt_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Position of an incoming item, wrapped into the frame
  always_comb begin
    r0 = in_data.first_of_frame ? '0 : HGT_W'(row_r);
    c0 = in_data.first_of_frame ? '0 : EW_W'(col_r);
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + HGT_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h_eff) ? '0 : r1;
  end

  // Item flags
  assign r_ge1  = (cur_row_r != '0);
  assign r_ge2  = (cur_row_r >= ROW_W'(2));
  assign c_ge1  = (cur_col_r != '0);
  assign c_ge2  = (cur_col_r >= COL_W'(2));
  assign c_last = (EW_W'(cur_col_r) + EW_W'(1) == w_eff);
  assign r_last = (HGT_W'(cur_row_r) + HGT_W'(1) == h_eff);
  assign cn     = EW_W'(cur_col_r) + EW_W'(1);
  assign rn     = HGT_W'(cur_row_r) + HGT_W'(1);
  assign mask_w = cell_mask(slot_r, r_ge1, r_ge2, c_ge1, c_ge2);

  // Result bookkeeping
  assign slot_bit = NUM_SLOTS'(1) << slot_r;
  assign rest     = pend_r & ~slot_bit;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign colx     = CX_W'(cur_col_r) - CX_W'(!slot_r[0]);

  // Line buffer port
  assign mem_addr  = (state_r == ST_IDLE) ? c1[COL_W-1:0] : cur_col_r;
  assign mem_we    = (state_r == ST_LOAD);
  assign mem_wdata = '{two_above: mem_rdata.above, above: px_r};

  // Shared unit drive
  always_comb begin
    alu_ctl = '{op: ALU_HOLD, first: 1'b0, incl: 1'b0};
    alu_pix = win_r[idx_r];
    case (state_r)
      ST_ACC:   alu_ctl = '{op: ALU_ACC, first: (idx_r == '0), incl: mask_w[idx_r]};
      ST_DINIT: alu_ctl.op = ALU_DINIT;
      ST_DIV:   alu_ctl.op = ALU_DSTEP;
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    dcnt_nxt      = dcnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    px_nxt        = px_r;
    wid_nxt       = wid_r;
    hgt_nxt       = hgt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    for (int i = 0; i < WIN_N; i++) begin
      win_nxt[i] = win_r[i];
    end

    // output register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // config write
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  wid_nxt = cfg_data[WID_W-1:0];
        CFG_HEIGHT: hgt_nxt = cfg_data[HGT_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cur_row_nxt = r2[ROW_W-1:0];
          cur_col_nxt = c1[COL_W-1:0];
          px_nxt      = {in_data.in_red, in_data.in_green, in_data.in_blue};
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // shift window left, bring in the new column
        for (int k = 0; k < 3; k++) begin
          win_nxt[k*3]   = win_r[k*3+1];
          win_nxt[k*3+1] = win_r[k*3+2];
        end
        win_nxt[2] = mem_rdata.two_above;
        win_nxt[5] = mem_rdata.above;
        win_nxt[8] = px_r;
        // advance position counters
        if (cn >= w_eff) begin
          col_nxt = '0;
          row_nxt = (rn >= h_eff) ? '0 : rn[ROW_W-1:0];
        end else begin
          col_nxt = cn[COL_W-1:0];
          row_nxt = cur_row_r;
        end
        pend_nxt = {r_last && c_last, r_last && c_ge1, r_ge1 && c_last, r_ge1 && c_ge1};
        slot_nxt = first_slot(pend_nxt);
        idx_nxt  = '0;
        state_nxt = (pend_nxt == '0) ? ST_IDLE : ST_ACC;
      end
      ST_ACC: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(WIN_N - 1)) begin
          state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: begin
        dcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        dcnt_nxt = dcnt_r + DSTEP_W'(1);
        if (dcnt_r == DSTEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_nxt.out_red     = alu_quo[2];
          out_nxt.out_green   = alu_quo[1];
          out_nxt.out_blue    = alu_quo[0];
          out_nxt.out_row     = cur_row_r - ROW_W'(!slot_r[1]);
          out_nxt.out_col     = colx[COL_OUT_W-1:0];
          out_nxt.last_of_run = (rest == '0);
          out_valid_nxt       = 1'b1;
          pend_nxt            = rest;
          slot_nxt            = first_slot(rest);
          idx_nxt             = '0;
          state_nxt           = (rest == '0) ? ST_IDLE : ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      slot_r      <= '0;
      idx_r       <= '0;
      dcnt_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      wid_r       <= WID_RST;
      hgt_r       <= HGT_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      slot_r      <= slot_nxt;
      idx_r       <= idx_nxt;
      dcnt_r      <= dcnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      wid_r       <= wid_nxt;
      hgt_r       <= hgt_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < WIN_N; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cur_row_r <= cur_row_nxt;
    cur_col_r <= cur_col_nxt;
    px_r      <= px_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BBR_CHK_NEXT(a_accept_loads, in_valid && !in_stall, state_r == ST_LOAD, "accepted item did not start a line read")
  `BBR_CHK_NOW(a_idle_no_pending, state_r == ST_IDLE, pend_r == '0, "results still pending in idle")
  `BBR_CHK_NEXT(a_last_ends_item, emit_go && out_nxt.last_of_run, state_r == ST_IDLE, "last result did not end the item")

endmodule

// ===== hdl/box_blur_3x3_rgb_unit.sv =====
// Top level of the 3x3 RGB box blur unit.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid / in_stall    | in_data: first flag, pixel RGB
//  out     | output    | out_valid / out_stall  | out_data: mean RGB, row, col, last
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data (width, height)
//
// An item with no result needs a line buffer read, then a window and buffer update.
// Each result runs on the shared three-lane unit: 9 accumulate steps, a set-up step,
// 8 divide steps and a hand-off to the output register; an item has n = 0..4 results.
// in_stall is high while an item is in work; a full output register held by out_stall
// delays only the hand-off, and the next item is taken while a result waits.
// Reset clears position counters and window, sets width 1024 and height 768; the line
// buffers are not cleared.
module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH = bbr_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bbr_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bbr_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbr_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [COL_W-1:0] mem_addr;
  logic             mem_we;
  line_pair_t       mem_wdata;
  line_pair_t       mem_rdata;
  alu_ctl_t         alu_ctl;
  rgb_t             alu_pix;
  rgb_t             alu_quo;

  bbr_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_addr  (mem_addr),
    .mem_we    (mem_we),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .alu_ctl   (alu_ctl),
    .alu_pix   (alu_pix),
    .alu_quo   (alu_quo)
  );

  bbr_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  bbr_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .pix   (alu_pix),
    .quo   (alu_quo)
  );

endmodule
